// ===== rtl/ebc_pkg.sv =====
// Shared widths, constants and the per-item side-band type of the collision pipeline.
package ebc_pkg;

    // Field widths
    localparam int POS_W  = 24;   // Q15.8 positions and velocities
    localparam int RAD_W  = 16;   // Q8.8 radii
    localparam int MASS_W = 16;   // integer masses

    // Internal widths
    localparam int DIF_W  = POS_W + 1;        // difference of two positions
    localparam int SQ_W   = 2 * DIF_W - 1;    // square of a difference magnitude
    localparam int SUM_W  = SQ_W + 1;         // d.d and w.w
    localparam int PRD_W  = 2 * DIF_W;        // signed product of two differences
    localparam int DOT_W  = PRD_W + 1;        // w.d
    localparam int RS_W   = RAD_W + 1;        // sum of radii
    localparam int RS2_W  = 2 * RS_W;         // squared sum of radii
    localparam int MSUM_W = MASS_W + 1;       // sum of masses
    localparam int LK_W   = 63;               // 2000*dot + w2
    localparam int HALF_W = 25;               // split point of the wide multiplies
    localparam int QP_W   = MSUM_W + HALF_W;  // partial product of (ma+mb)*d2
    localparam int Q_W    = 50;               // quotient bits of the factor
    localparam int QF_W   = MSUM_W + SUM_W;   // (ma+mb)*d2
    localparam int DEN_W  = QF_W + 1;         // 2*(ma+mb)*d2
    localparam int NUM_W  = 77;               // |dot|*2^26 + (ma+mb)*d2
    localparam int AD_W   = DOT_W - 1;        // |dot|
    localparam int P1_W   = 49;               // |f|*|d| per axis
    localparam int ML_W   = HALF_W + MASS_W;  // low partial of m*|f|*|d|
    localparam int MH_W   = P1_W - HALF_W + MASS_W; // high partial
    localparam int PM_W   = 51;               // m*|f|*|d|
    localparam int R_W    = 27;               // rounded correction
    localparam int T_W    = 29;               // speed plus correction

    localparam int LOOK_RECIP = 2000;
    localparam int FRAC_BITS  = 24;
    localparam int DIV_STEPS  = Q_W;

    localparam logic signed [T_W-1:0] SAT_HI = 29'sd8388607;
    localparam logic signed [T_W-1:0] SAT_LO = -29'sd8388608;

    // Side band that travels with each item through the pipeline
    typedef struct packed {
        logic signed [POS_W-1:0] vax;
        logic signed [POS_W-1:0] vay;
        logic signed [POS_W-1:0] vbx;
        logic signed [POS_W-1:0] vby;
        logic [MASS_W-1:0]       ma;
        logic [MASS_W-1:0]       mb;
        logic [DIF_W-1:0]        adx;
        logic [DIF_W-1:0]        ady;
        logic                    sdx;
        logic                    sdy;
        logic                    fneg;
        logic                    coll;
        logic                    degen;
    } ebc_side_t;

endpackage

// ===== rtl/elastic_ball_collision_2d.sv =====
// Two-circle elastic collision engine. One transaction enters per clock when the output side
// takes results. Each result passes through the geometry and collision test, then the divider
// that forms the shared impulse factor (one quotient bit per stage), then the correction
// multiplies, rounding and saturation ending in the output register. A stall on the output
// freezes the whole pipeline; nothing is lost or repeated. The block keeps no state between
// transactions.
module elastic_ball_collision_2d (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic signed [ebc_pkg::POS_W-1:0] centre_a_x,
    input  logic signed [ebc_pkg::POS_W-1:0] centre_a_y,
    input  logic signed [ebc_pkg::POS_W-1:0] centre_b_x,
    input  logic signed [ebc_pkg::POS_W-1:0] centre_b_y,
    input  logic signed [ebc_pkg::POS_W-1:0] speed_a_x,
    input  logic signed [ebc_pkg::POS_W-1:0] speed_a_y,
    input  logic signed [ebc_pkg::POS_W-1:0] speed_b_x,
    input  logic signed [ebc_pkg::POS_W-1:0] speed_b_y,
    input  logic [ebc_pkg::RAD_W-1:0]        radius_a,
    input  logic [ebc_pkg::RAD_W-1:0]        radius_b,
    input  logic [ebc_pkg::MASS_W-1:0]       mass_a,
    input  logic [ebc_pkg::MASS_W-1:0]       mass_b,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic signed [ebc_pkg::POS_W-1:0] new_speed_a_x,
    output logic signed [ebc_pkg::POS_W-1:0] new_speed_a_y,
    output logic signed [ebc_pkg::POS_W-1:0] new_speed_b_x,
    output logic signed [ebc_pkg::POS_W-1:0] new_speed_b_y,
    output logic                             collided,
    output logic                             degenerate,
    output logic                             saturated
);
    import ebc_pkg::*;

    logic             en;
    logic             prep_valid;
    logic [NUM_W-1:0] prep_num;
    logic [DEN_W-1:0] prep_den;
    ebc_side_t        prep_side;
    logic             div_valid;
    logic [Q_W-1:0]   div_quot;
    ebc_side_t        div_side;

    // Pipeline advances unless a finished result is held
    assign en       = !out_valid || out_ready;
    assign in_ready = en;

    ebc_prep u_prep (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .in_valid   (in_valid),
        .centre_a_x (centre_a_x),
        .centre_a_y (centre_a_y),
        .centre_b_x (centre_b_x),
        .centre_b_y (centre_b_y),
        .speed_a_x  (speed_a_x),
        .speed_a_y  (speed_a_y),
        .speed_b_x  (speed_b_x),
        .speed_b_y  (speed_b_y),
        .radius_a   (radius_a),
        .radius_b   (radius_b),
        .mass_a     (mass_a),
        .mass_b     (mass_b),
        .out_valid  (prep_valid),
        .num        (prep_num),
        .den        (prep_den),
        .side       (prep_side)
    );

    ebc_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (prep_valid),
        .num       (prep_num),
        .den       (prep_den),
        .side      (prep_side),
        .res_valid (div_valid),
        .quot      (div_quot),
        .res_side  (div_side)
    );

    ebc_apply u_apply (
        .clk           (clk),
        .rst_n         (rst_n),
        .en            (en),
        .in_valid      (div_valid),
        .quot          (div_quot),
        .side          (div_side),
        .out_valid     (out_valid),
        .new_speed_a_x (new_speed_a_x),
        .new_speed_a_y (new_speed_a_y),
        .new_speed_b_x (new_speed_b_x),
        .new_speed_b_y (new_speed_b_y),
        .collided      (collided),
        .degenerate    (degenerate),
        .saturated     (saturated)
    );

    // Clipping only happens on an applied collision
    a_sat_needs_coll: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && saturated) |-> collided)
        else $error("saturated without collision");

    // Coincident centres never report a collision
    a_coll_not_degen: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && collided) |-> !degenerate)
        else $error("collision reported for coincident centres");

    // Pass-through results carry the input speeds unchanged, so no clip flag
    a_degen_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && degenerate) |-> (!collided && !saturated))
        else $error("degenerate result carries collision flags");

endmodule

// ===== rtl/ebc_prep.sv =====
// Geometry front end: differences, squares, dot product, collision test, divider operands.
module ebc_prep (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              en,
    input  logic                              in_valid,
    input  logic signed [ebc_pkg::POS_W-1:0]  centre_a_x,
    input  logic signed [ebc_pkg::POS_W-1:0]  centre_a_y,
    input  logic signed [ebc_pkg::POS_W-1:0]  centre_b_x,
    input  logic signed [ebc_pkg::POS_W-1:0]  centre_b_y,
    input  logic signed [ebc_pkg::POS_W-1:0]  speed_a_x,
    input  logic signed [ebc_pkg::POS_W-1:0]  speed_a_y,
    input  logic signed [ebc_pkg::POS_W-1:0]  speed_b_x,
    input  logic signed [ebc_pkg::POS_W-1:0]  speed_b_y,
    input  logic [ebc_pkg::RAD_W-1:0]         radius_a,
    input  logic [ebc_pkg::RAD_W-1:0]         radius_b,
    input  logic [ebc_pkg::MASS_W-1:0]        mass_a,
    input  logic [ebc_pkg::MASS_W-1:0]        mass_b,
    output logic                              out_valid,
    output logic [ebc_pkg::NUM_W-1:0]         num,
    output logic [ebc_pkg::DEN_W-1:0]         den,
    output ebc_pkg::ebc_side_t                side
);
    import ebc_pkg::*;

    // Stage 1: differences
    logic                    v1_reg;
    logic signed [DIF_W-1:0] dx_reg, dy_reg, wx_reg, wy_reg;
    logic signed [DIF_W-1:0] dx_next, dy_next, wx_next, wy_next;
    logic [RS_W-1:0]         rs_reg, rs_next;
    ebc_side_t               side1_reg, side1_next;

    // Stage 2: products
    logic                    v2_reg;
    logic [DIF_W-1:0]        adx_c, ady_c, awx_c, awy_c;
    logic [2*DIF_W-1:0]      sq_dx_c, sq_dy_c, sq_wx_c, sq_wy_c;
    logic [SQ_W-1:0]         sqdx_reg, sqdy_reg, sqwx_reg, sqwy_reg;
    logic [SQ_W-1:0]         sqdx_next, sqdy_next, sqwx_next, sqwy_next;
    logic signed [PRD_W-1:0] pdx_reg, pdy_reg, pdx_next, pdy_next;
    logic [RS2_W-1:0]        rs2_reg, rs2_next;
    logic [MSUM_W-1:0]       msum_reg, msum_next;
    ebc_side_t               side2_reg, side2_next;

    // Stage 3: sums
    logic                    v3_reg;
    logic [SUM_W-1:0]        d2_reg, w2_reg, d2_next, w2_next;
    logic signed [DOT_W-1:0] dot_reg, dot_next;
    logic [RS2_W-1:0]        rs2_3_reg;
    logic [MSUM_W-1:0]       msum3_reg;
    ebc_side_t               side3_reg;

    // Stage 4: test terms and divisor partials
    logic                    v4_reg;
    logic                    touch_reg, touch_next;
    logic [LK_W-1:0]         lk_reg, lk_next;
    logic [DOT_W-1:0]        ndot_c;
    logic [AD_W-1:0]         ad_reg, ad_next;
    logic [QP_W-1:0]         qlo_reg, qhi_reg, qlo_next, qhi_next;
    ebc_side_t               side4_reg, side4_next;

    // Stage 5: collision decision and divider operands
    logic                    v5_reg;
    logic [QF_W-1:0]         q_c;
    logic                    sep_c;
    logic [NUM_W-1:0]        num_reg, num_next;
    logic [DEN_W-1:0]        den_reg, den_next;
    ebc_side_t               side5_reg, side5_next;

    // Stage 1 logic
    always_comb begin
        dx_next = {centre_a_x[POS_W-1], centre_a_x} - {centre_b_x[POS_W-1], centre_b_x};
        dy_next = {centre_a_y[POS_W-1], centre_a_y} - {centre_b_y[POS_W-1], centre_b_y};
        wx_next = {speed_a_x[POS_W-1], speed_a_x} - {speed_b_x[POS_W-1], speed_b_x};
        wy_next = {speed_a_y[POS_W-1], speed_a_y} - {speed_b_y[POS_W-1], speed_b_y};
        rs_next = {1'b0, radius_a} + {1'b0, radius_b};
        side1_next     = '0;
        side1_next.vax = speed_a_x;
        side1_next.vay = speed_a_y;
        side1_next.vbx = speed_b_x;
        side1_next.vby = speed_b_y;
        // zero mass counts as one
        side1_next.ma  = (mass_a == '0) ? MASS_W'(1) : mass_a;
        side1_next.mb  = (mass_b == '0) ? MASS_W'(1) : mass_b;
    end

    // Stage 2 logic
    always_comb begin
        adx_c = dx_reg[DIF_W-1] ? (~dx_reg + DIF_W'(1)) : dx_reg;
        ady_c = dy_reg[DIF_W-1] ? (~dy_reg + DIF_W'(1)) : dy_reg;
        awx_c = wx_reg[DIF_W-1] ? (~wx_reg + DIF_W'(1)) : wx_reg;
        awy_c = wy_reg[DIF_W-1] ? (~wy_reg + DIF_W'(1)) : wy_reg;
        sq_dx_c   = adx_c * adx_c;
        sq_dy_c   = ady_c * ady_c;
        sq_wx_c   = awx_c * awx_c;
        sq_wy_c   = awy_c * awy_c;
        sqdx_next = sq_dx_c[SQ_W-1:0];
        sqdy_next = sq_dy_c[SQ_W-1:0];
        sqwx_next = sq_wx_c[SQ_W-1:0];
        sqwy_next = sq_wy_c[SQ_W-1:0];
        pdx_next  = dx_reg * wx_reg;
        pdy_next  = dy_reg * wy_reg;
        rs2_next  = rs_reg * rs_reg;
        msum_next = {1'b0, side1_reg.ma} + {1'b0, side1_reg.mb};
        side2_next       = side1_reg;
        side2_next.adx   = adx_c;
        side2_next.ady   = ady_c;
        side2_next.sdx   = dx_reg[DIF_W-1];
        side2_next.sdy   = dy_reg[DIF_W-1];
        side2_next.degen = (dx_reg == '0) && (dy_reg == '0);
    end

    // Stage 3 logic
    always_comb begin
        d2_next  = {1'b0, sqdx_reg} + {1'b0, sqdy_reg};
        w2_next  = {1'b0, sqwx_reg} + {1'b0, sqwy_reg};
        dot_next = {pdx_reg[PRD_W-1], pdx_reg} + {pdy_reg[PRD_W-1], pdy_reg};
    end

    // Stage 4 logic: touch test, look-ahead term, |dot|, (ma+mb)*d2 partials
    always_comb begin
        touch_next = {{(SUM_W-RS2_W){1'b0}}, rs2_3_reg} >= d2_reg;
        lk_next    = {{(LK_W-DOT_W){dot_reg[DOT_W-1]}}, dot_reg} * LK_W'(LOOK_RECIP)
                   + {{(LK_W-SUM_W){1'b0}}, w2_reg};
        ndot_c     = ~dot_reg + DOT_W'(1);
        ad_next    = dot_reg[DOT_W-1] ? ndot_c[AD_W-1:0] : dot_reg[AD_W-1:0];
        qlo_next   = msum3_reg * d2_reg[HALF_W-1:0];
        qhi_next   = msum3_reg * d2_reg[SUM_W-1:HALF_W];
        side4_next      = side3_reg;
        side4_next.fneg = dot_reg[DOT_W-1];
    end

    // Stage 5 logic
    always_comb begin
        q_c      = {{(QF_W-QP_W){1'b0}}, qlo_reg} + {qhi_reg, {HALF_W{1'b0}}};
        num_next = {{(NUM_W-QF_W){1'b0}}, q_c} + {1'b0, ad_reg, {(FRAC_BITS+2){1'b0}}};
        den_next = {q_c, 1'b0};
        sep_c    = lk_reg[LK_W-1] || (lk_reg == '0);
        side5_next      = side4_reg;
        side5_next.coll = touch_reg && sep_c && !side4_reg.degen;
    end

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dx_reg    <= dx_next;
            dy_reg    <= dy_next;
            wx_reg    <= wx_next;
            wy_reg    <= wy_next;
            rs_reg    <= rs_next;
            side1_reg <= side1_next;

            sqdx_reg  <= sqdx_next;
            sqdy_reg  <= sqdy_next;
            sqwx_reg  <= sqwx_next;
            sqwy_reg  <= sqwy_next;
            pdx_reg   <= pdx_next;
            pdy_reg   <= pdy_next;
            rs2_reg   <= rs2_next;
            msum_reg  <= msum_next;
            side2_reg <= side2_next;

            d2_reg    <= d2_next;
            w2_reg    <= w2_next;
            dot_reg   <= dot_next;
            rs2_3_reg <= rs2_reg;
            msum3_reg <= msum_reg;
            side3_reg <= side2_reg;

            touch_reg <= touch_next;
            lk_reg    <= lk_next;
            ad_reg    <= ad_next;
            qlo_reg   <= qlo_next;
            qhi_reg   <= qhi_next;
            side4_reg <= side4_next;

            num_reg   <= num_next;
            den_reg   <= den_next;
            side5_reg <= side5_next;
        end
    end

    assign out_valid = v5_reg;
    assign num       = num_reg;
    assign den       = den_reg;
    assign side      = side5_reg;

endmodule

// ===== rtl/ebc_div.sv =====
// Pipelined restoring divider: one quotient bit per stage for the shared impulse factor.
module ebc_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          in_valid,
    input  logic [ebc_pkg::NUM_W-1:0]     num,
    input  logic [ebc_pkg::DEN_W-1:0]     den,
    input  ebc_pkg::ebc_side_t            side,
    output logic                          res_valid,
    output logic [ebc_pkg::Q_W-1:0]       quot,
    output ebc_pkg::ebc_side_t            res_side
);
    import ebc_pkg::*;

    logic             valid_reg [DIV_STEPS];
    logic [DEN_W-1:0] rem_reg   [DIV_STEPS];
    logic [DEN_W-1:0] den_reg   [DIV_STEPS];
    logic [Q_W-1:0]   nlo_reg   [DIV_STEPS];
    logic [Q_W-1:0]   quot_reg  [DIV_STEPS];
    ebc_side_t        side_reg  [DIV_STEPS];

    for (genvar s = 0; s < DIV_STEPS; s++)
    begin : g_step
        logic             valid_in;
        logic [DEN_W-1:0] rem_in;
        logic [DEN_W-1:0] den_in;
        logic [Q_W-1:0]   nlo_in;
        logic [Q_W-1:0]   quot_in;
        ebc_side_t        side_in;
        logic [DEN_W:0]   trial;
        logic             take;
        logic [DEN_W-1:0] rem_next;
        logic [Q_W-1:0]   nlo_next;
        logic [Q_W-1:0]   quot_next;

        if (s == 0)
        begin : g_head
            // quotient fits in Q_W bits, so the top of the dividend starts below the divisor
            assign valid_in = in_valid;
            assign rem_in   = DEN_W'(num[NUM_W-1:Q_W]);
            assign den_in   = den;
            assign nlo_in   = num[Q_W-1:0];
            assign quot_in  = '0;
            assign side_in  = side;
        end
        else
        begin : g_body
            assign valid_in = valid_reg[s-1];
            assign rem_in   = rem_reg[s-1];
            assign den_in   = den_reg[s-1];
            assign nlo_in   = nlo_reg[s-1];
            assign quot_in  = quot_reg[s-1];
            assign side_in  = side_reg[s-1];
        end

        // Shift in one dividend bit, subtract when it fits
        always_comb begin
            trial     = {rem_in, nlo_in[Q_W-1]};
            take      = trial >= {1'b0, den_in};
            rem_next  = take ? DEN_W'(trial - {1'b0, den_in}) : trial[DEN_W-1:0];
            nlo_next  = {nlo_in[Q_W-2:0], 1'b0};
            quot_next = {quot_in[Q_W-2:0], take};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[s] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[s] <= valid_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[s]  <= rem_next;
                den_reg[s]  <= den_in;
                nlo_reg[s]  <= nlo_next;
                quot_reg[s] <= quot_next;
                side_reg[s] <= side_in;
            end
        end
    end

    assign res_valid = valid_reg[DIV_STEPS-1];
    assign quot      = quot_reg[DIV_STEPS-1];
    assign res_side  = side_reg[DIV_STEPS-1];

    // A colliding pair always leaves a remainder below the divisor
    a_rem_below_den: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res_side.coll) |-> (rem_reg[DIV_STEPS-1] < den_reg[DIV_STEPS-1]))
        else $error("divider remainder not below divisor");

endmodule

// ===== rtl/ebc_apply.sv =====
// Back end: per-axis velocity corrections, rounding, saturation and the output register.
module ebc_apply (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             en,
    input  logic                             in_valid,
    input  logic [ebc_pkg::Q_W-1:0]          quot,
    input  ebc_pkg::ebc_side_t               side,
    output logic                             out_valid,
    output logic signed [ebc_pkg::POS_W-1:0] new_speed_a_x,
    output logic signed [ebc_pkg::POS_W-1:0] new_speed_a_y,
    output logic signed [ebc_pkg::POS_W-1:0] new_speed_b_x,
    output logic signed [ebc_pkg::POS_W-1:0] new_speed_b_y,
    output logic                             collided,
    output logic                             degenerate,
    output logic                             saturated
);
    import ebc_pkg::*;

    // Round m*|f|*|d| / 2^24 to nearest, ties away from zero
    function automatic logic [R_W-1:0] round_corr(input logic [ML_W-1:0] lo,
                                                  input logic [MH_W-1:0] hi);
        logic [PM_W-1:0] sum;
        begin
            sum = {{(PM_W-ML_W){1'b0}}, lo} + {hi[PM_W-HALF_W-1:0], {HALF_W{1'b0}}}
                + (PM_W'(1) << (FRAC_BITS - 1));
            return sum[PM_W-1:FRAC_BITS];
        end
    endfunction

    // Add or subtract a correction, clip to the velocity range; MSB is the clip flag
    function automatic logic [POS_W:0] sat_add(input logic [POS_W-1:0] v,
                                               input logic [R_W-1:0] r,
                                               input logic sub);
        logic signed [T_W-1:0] t;
        logic signed [T_W-1:0] ve;
        logic signed [T_W-1:0] re;
        begin
            ve = {{(T_W-POS_W){v[POS_W-1]}}, v};
            re = {{(T_W-R_W){1'b0}}, r};
            t  = sub ? (ve - re) : (ve + re);
            if (t > SAT_HI)
                return {1'b1, SAT_HI[POS_W-1:0]};
            else if (t < SAT_LO)
                return {1'b1, SAT_LO[POS_W-1:0]};
            else
                return {1'b0, t[POS_W-1:0]};
        end
    endfunction

    // Stage A1: |f| times |d| in two halves
    logic                   v1_reg;
    logic [2*HALF_W-1:0]    mxl_reg, mxh_reg, myl_reg, myh_reg;
    logic [2*HALF_W-1:0]    mxl_next, mxh_next, myl_next, myh_next;
    ebc_side_t              side1_reg;

    // Stage A2: recombine
    logic                   v2_reg;
    logic [P1_W-1:0]        p1x_reg, p1y_reg, p1x_next, p1y_next;
    ebc_side_t              side2_reg;

    // Stage A3: times mass in two halves
    logic                   v3_reg;
    logic [ML_W-1:0]        axl_reg, ayl_reg, bxl_reg, byl_reg;
    logic [ML_W-1:0]        axl_next, ayl_next, bxl_next, byl_next;
    logic [MH_W-1:0]        axh_reg, ayh_reg, bxh_reg, byh_reg;
    logic [MH_W-1:0]        axh_next, ayh_next, bxh_next, byh_next;
    ebc_side_t              side3_reg;

    // Stage A4: rounded magnitudes and signs
    logic                   v4_reg;
    logic [R_W-1:0]         rax_reg, ray_reg, rbx_reg, rby_reg;
    logic [R_W-1:0]         rax_next, ray_next, rbx_next, rby_next;
    logic                   negx_reg, negy_reg, negx_next, negy_next;
    ebc_side_t              side4_reg;

    // Stage A5: output register
    logic                   v5_reg;
    logic [POS_W:0]         sa_x_c, sa_y_c, sb_x_c, sb_y_c;
    logic signed [POS_W-1:0] nax_reg, nay_reg, nbx_reg, nby_reg;
    logic signed [POS_W-1:0] nax_next, nay_next, nbx_next, nby_next;
    logic                   coll_reg, degen_reg, sat_reg, sat_next;

    always_comb begin
        mxl_next = quot[HALF_W-1:0] * side.adx;
        mxh_next = quot[Q_W-1:HALF_W] * side.adx;
        myl_next = quot[HALF_W-1:0] * side.ady;
        myh_next = quot[Q_W-1:HALF_W] * side.ady;
    end

    always_comb begin
        p1x_next = mxl_reg[P1_W-1:0] + {mxh_reg[P1_W-HALF_W-1:0], {HALF_W{1'b0}}};
        p1y_next = myl_reg[P1_W-1:0] + {myh_reg[P1_W-HALF_W-1:0], {HALF_W{1'b0}}};
    end

    // A side scales by mb, B side by ma
    always_comb begin
        axl_next = p1x_reg[HALF_W-1:0] * side2_reg.mb;
        axh_next = p1x_reg[P1_W-1:HALF_W] * side2_reg.mb;
        ayl_next = p1y_reg[HALF_W-1:0] * side2_reg.mb;
        ayh_next = p1y_reg[P1_W-1:HALF_W] * side2_reg.mb;
        bxl_next = p1x_reg[HALF_W-1:0] * side2_reg.ma;
        bxh_next = p1x_reg[P1_W-1:HALF_W] * side2_reg.ma;
        byl_next = p1y_reg[HALF_W-1:0] * side2_reg.ma;
        byh_next = p1y_reg[P1_W-1:HALF_W] * side2_reg.ma;
    end

    always_comb begin
        rax_next  = round_corr(axl_reg, axh_reg);
        ray_next  = round_corr(ayl_reg, ayh_reg);
        rbx_next  = round_corr(bxl_reg, bxh_reg);
        rby_next  = round_corr(byl_reg, byh_reg);
        negx_next = side3_reg.fneg ^ side3_reg.sdx;
        negy_next = side3_reg.fneg ^ side3_reg.sdy;
    end

    // A loses the correction, B gains it; pass through when no collision
    always_comb begin
        sa_x_c = sat_add(side4_reg.vax, rax_reg, !negx_reg);
        sa_y_c = sat_add(side4_reg.vay, ray_reg, !negy_reg);
        sb_x_c = sat_add(side4_reg.vbx, rbx_reg, negx_reg);
        sb_y_c = sat_add(side4_reg.vby, rby_reg, negy_reg);
        if (side4_reg.coll)
        begin
            nax_next = sa_x_c[POS_W-1:0];
            nay_next = sa_y_c[POS_W-1:0];
            nbx_next = sb_x_c[POS_W-1:0];
            nby_next = sb_y_c[POS_W-1:0];
            sat_next = sa_x_c[POS_W] | sa_y_c[POS_W] | sb_x_c[POS_W] | sb_y_c[POS_W];
        end
        else
        begin
            nax_next = side4_reg.vax;
            nay_next = side4_reg.vay;
            nbx_next = side4_reg.vbx;
            nby_next = side4_reg.vby;
            sat_next = 1'b0;
        end
    end

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mxl_reg   <= mxl_next;
            mxh_reg   <= mxh_next;
            myl_reg   <= myl_next;
            myh_reg   <= myh_next;
            side1_reg <= side;

            p1x_reg   <= p1x_next;
            p1y_reg   <= p1y_next;
            side2_reg <= side1_reg;

            axl_reg   <= axl_next;
            axh_reg   <= axh_next;
            ayl_reg   <= ayl_next;
            ayh_reg   <= ayh_next;
            bxl_reg   <= bxl_next;
            bxh_reg   <= bxh_next;
            byl_reg   <= byl_next;
            byh_reg   <= byh_next;
            side3_reg <= side2_reg;

            rax_reg   <= rax_next;
            ray_reg   <= ray_next;
            rbx_reg   <= rbx_next;
            rby_reg   <= rby_next;
            negx_reg  <= negx_next;
            negy_reg  <= negy_next;
            side4_reg <= side3_reg;

            nax_reg   <= nax_next;
            nay_reg   <= nay_next;
            nbx_reg   <= nbx_next;
            nby_reg   <= nby_next;
            coll_reg  <= side4_reg.coll;
            degen_reg <= side4_reg.degen;
            sat_reg   <= sat_next;
        end
    end

    assign out_valid     = v5_reg;
    assign new_speed_a_x = nax_reg;
    assign new_speed_a_y = nay_reg;
    assign new_speed_b_x = nbx_reg;
    assign new_speed_b_y = nby_reg;
    assign collided      = coll_reg;
    assign degenerate    = degen_reg;
    assign saturated     = sat_reg;

    // For a colliding pair the factor stays below 2^49
    a_factor_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && side.coll) |-> !quot[Q_W-1])
        else $error("impulse factor out of range");

endmodule
